FILE: hw/rtl/two_point_sensor_calibration_defines.svh
// Assertion helpers for the calibration block.
`ifndef TWO_POINT_SENSOR_CALIBRATION_DEFINES_SVH
`define TWO_POINT_SENSOR_CALIBRATION_DEFINES_SVH

// Same-cycle implication, off during reset.
`define TPSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: property failed");

// Next-cycle implication, off during reset.
`define TPSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: property failed");

`endif

FILE: hw/rtl/tpsc_pkg.sv
package tpsc_pkg;

   localparam int CHANNELS    = 3;
   localparam int SAMPLE_BITS = 12;
   localparam int REF_W       = 2;
   localparam int SLOPE_W     = 19;
   localparam int OFFSET_W    = 32;
   localparam int DEN_W       = SAMPLE_BITS + 1;
   localparam int PROD_W      = 2 * SAMPLE_BITS;

   localparam longint MAX_SAMPLE = (64'sd1 << SAMPLE_BITS) - 64'sd1;
   localparam int NUM_W = $clog2(200 * MAX_SAMPLE * MAX_SAMPLE + MAX_SAMPLE + 1);
   localparam int EXT_W = (NUM_W > OFFSET_W) ? NUM_W : OFFSET_W;

   localparam int SCALE2    = 200;
   localparam int SLOPE_ONE = 100;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type light_left;
      sample_type light_middle;
      sample_type light_right;
      sample_type dark_left;
      sample_type dark_middle;
      sample_type dark_right;
   } tpsc_req_type;

   typedef struct packed {
      logic [REF_W-1:0]           reference_channel;
      logic                       range_error;
      logic [SLOPE_W-1:0]         slope_left;
      logic [SLOPE_W-1:0]         slope_middle;
      logic [SLOPE_W-1:0]         slope_right;
      logic signed [OFFSET_W-1:0] offset_left;
      logic signed [OFFSET_W-1:0] offset_middle;
      logic signed [OFFSET_W-1:0] offset_right;
   } tpsc_rsp_type;

   typedef struct packed {
      logic [CHANNELS-1:0]           neg;
      logic [REF_W-1:0]              refc;
      logic                          err;
   } tpsc_side_type;

   typedef struct packed {
      logic [CHANNELS-1:0][NUM_W-1:0] snum;
      logic [CHANNELS-1:0][NUM_W-1:0] onum;
      logic [CHANNELS-1:0][DEN_W-1:0] den;
      tpsc_side_type                  side;
   } tpsc_num_type;

endpackage

FILE: hw/rtl/tpsc_front.sv
module tpsc_front
   import tpsc_pkg::*;
(
   input  logic         clock,
   input  logic [2:0]   stage_en,
   input  tpsc_req_type req_data,
   output tpsc_num_type num_out
);

   sample_type                  light_in [CHANNELS];
   sample_type                  dark_in  [CHANNELS];
   sample_type                  light_ff [CHANNELS];
   sample_type                  dark_ff  [CHANNELS];
   logic [REF_W-1:0]            refc_in, refc_ff, refc2_ff;

   logic signed [SAMPLE_BITS:0] rr_in, rr_ff;
   logic signed [SAMPLE_BITS:0] ii_in [CHANNELS];
   logic signed [SAMPLE_BITS:0] ii_ff [CHANNELS];
   logic [PROD_W-1:0]           p1_in [CHANNELS];
   logic [PROD_W-1:0]           p2_in [CHANNELS];
   logic [PROD_W-1:0]           p1_ff [CHANNELS];
   logic [PROD_W-1:0]           p2_ff [CHANNELS];
   logic                        err_in, err2_ff;

   tpsc_num_type                num_in, num_ff;

   // stage 1: unpack, pick reference
   always_comb begin
      light_in[0] = req_data.light_left;
      light_in[1] = req_data.light_middle;
      light_in[2] = req_data.light_right;
      dark_in[0]  = req_data.dark_left;
      dark_in[1]  = req_data.dark_middle;
      dark_in[2]  = req_data.dark_right;
      refc_in     = '0;
      for (int c = 1; c < CHANNELS; c++) begin
         if (light_in[c] > light_in[refc_in]) begin
            refc_in = REF_W'(c);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         light_ff <= light_in;
         dark_ff  <= dark_in;
         refc_ff  <= refc_in;
      end
   end

   // stage 2: ranges, error, cross products
   always_comb begin
      rr_in  = $signed({1'b0, light_ff[refc_ff]}) - $signed({1'b0, dark_ff[refc_ff]});
      err_in = (rr_in <= 0);
      for (int c = 0; c < CHANNELS; c++) begin
         ii_in[c] = $signed({1'b0, light_ff[c]}) - $signed({1'b0, dark_ff[c]});
         if ((REF_W'(c) != refc_ff) && (ii_in[c] <= 0)) begin
            err_in = 1'b1;
         end
         p1_in[c] = {{SAMPLE_BITS{1'b0}}, ii_in[c][SAMPLE_BITS-1:0]}
                  * {{SAMPLE_BITS{1'b0}}, dark_ff[refc_ff]};
         p2_in[c] = {{SAMPLE_BITS{1'b0}}, rr_in[SAMPLE_BITS-1:0]}
                  * {{SAMPLE_BITS{1'b0}}, dark_ff[c]};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         rr_ff    <= rr_in;
         ii_ff    <= ii_in;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         err2_ff  <= err_in;
         refc2_ff <= refc_ff;
      end
   end

   // stage 3: rounding numerators and doubled divisors
   always_comb begin
      logic signed [PROD_W:0] diff;
      logic [PROD_W-1:0]      mag;
      num_in.side.refc = refc2_ff;
      num_in.side.err  = err2_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         diff = $signed({1'b0, p1_ff[c]}) - $signed({1'b0, p2_ff[c]});
         num_in.side.neg[c] = diff[PROD_W];
         mag = diff[PROD_W] ? PROD_W'(-diff) : diff[PROD_W-1:0];
         num_in.onum[c] = NUM_W'(mag) * NUM_W'(SCALE2)
                        + NUM_W'(ii_ff[c][SAMPLE_BITS-1:0]);
         num_in.snum[c] = NUM_W'(rr_ff[SAMPLE_BITS-1:0]) * NUM_W'(SCALE2)
                        + NUM_W'(ii_ff[c][SAMPLE_BITS-1:0]);
         num_in.den[c]  = {ii_ff[c][SAMPLE_BITS-1:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         num_ff <= num_in;
      end
   end

   assign num_out = num_ff;

endmodule

FILE: hw/rtl/tpsc_div_lane.sv
module tpsc_div_lane
   import tpsc_pkg::*;
(
   input  logic               clock,
   input  logic [NUM_W-1:0]   stage_en,
   input  logic [NUM_W-1:0]   num_in,
   input  logic [DEN_W-1:0]   den_in,
   output logic [NUM_W-1:0]   quo_out
);

   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [NUM_W-1:0] quo_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [NUM_W-1:0] num_prev, quo_prev;
      logic [DEN_W-1:0] rem_prev, den_prev, rem_nxt;
      logic [DEN_W:0]   trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign num_prev = num_in;
         assign quo_prev = '0;
         assign rem_prev = '0;
         assign den_prev = den_in;
      end else begin : g_next
         assign num_prev = num_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
      end

      always_comb begin
         trial   = {rem_prev, num_prev[NUM_W-1]};
         ge      = (trial >= {1'b0, den_prev});
         rem_nxt = ge ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            num_ff[k] <= {num_prev[NUM_W-2:0], 1'b0};
            quo_ff[k] <= {quo_prev[NUM_W-2:0], ge};
            rem_ff[k] <= rem_nxt;
            den_ff[k] <= den_prev;
         end
      end
   end

   assign quo_out = quo_ff[NUM_W-1];

endmodule

FILE: hw/rtl/two_point_sensor_calibration.sv
// Two-point linear calibration of three sensor channels.
// Input channel req_*: one transfer carries the light and dark samples of all
// channels. Result channel rsp_*: one transfer per input transfer, in order,
// with the reference channel, the range error flag, and each channel's slope
// and offset in hundredths, rounded half away from zero.
// Pipeline: three front stages (reference pick, cross products, numerators),
// one restoring-division stage per numerator bit, and the output register.
// Throughput: one item per cycle while rsp_ready is high; every stage holds
// its own valid bit and takes a new item whenever it is empty or the stage
// after it moves. Reset clears all valid bits; the datapath holds no state
// between items. When rsp_ready is low the result holds and items close up
// behind it; req_ready drops only once every stage is full.
module two_point_sensor_calibration
   import tpsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  tpsc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output tpsc_rsp_type rsp_data
);

   localparam int NS = 3 + NUM_W + 1;

   logic [NS-1:0]      valid_ff;
   logic [NS-1:0]      rdy;
   tpsc_num_type       num;
   tpsc_side_type      side_ff [NUM_W];
   logic [NUM_W-1:0]   squo [CHANNELS];
   logic [NUM_W-1:0]   oquo [CHANNELS];
   tpsc_rsp_type       out_in, out_ff;

   assign rdy[NS-1] = !valid_ff[NS-1] || rsp_ready;
   for (genvar k = 0; k < NS - 1; k++) begin : g_rdy
      assign rdy[k] = !valid_ff[k] || rdy[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   tpsc_front u_front (
      .clock    (clock),
      .stage_en (rdy[2:0]),
      .req_data (req_data),
      .num_out  (num)
   );

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      tpsc_div_lane u_slope (
         .clock    (clock),
         .stage_en (rdy[3 +: NUM_W]),
         .num_in   (num.snum[c]),
         .den_in   (num.den[c]),
         .quo_out  (squo[c])
      );
      tpsc_div_lane u_offset (
         .clock    (clock),
         .stage_en (rdy[3 +: NUM_W]),
         .num_in   (num.onum[c]),
         .den_in   (num.den[c]),
         .quo_out  (oquo[c])
      );
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_W; k++) begin
         if (rdy[3 + k]) begin
            side_ff[k] <= (k == 0) ? num.side : side_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_comb begin
      logic [SLOPE_W-1:0]  slope [CHANNELS];
      logic [OFFSET_W-1:0] offset [CHANNELS];
      logic [EXT_W-1:0]    mag;
      tpsc_side_type       sd;
      sd = side_ff[NUM_W-1];
      for (int c = 0; c < CHANNELS; c++) begin
         mag = EXT_W'(oquo[c]);
         if (sd.err) begin
            slope[c]  = '0;
            offset[c] = '0;
         end else if (REF_W'(c) == sd.refc) begin
            slope[c]  = SLOPE_W'(SLOPE_ONE);
            offset[c] = '0;
         end else begin
            slope[c]  = squo[c][SLOPE_W-1:0];
            offset[c] = sd.neg[c] ? OFFSET_W'(-mag) : OFFSET_W'(mag);
         end
      end
      out_in.reference_channel = sd.refc;
      out_in.range_error       = sd.err;
      out_in.slope_left        = slope[0];
      out_in.slope_middle      = slope[1];
      out_in.slope_right       = slope[2];
      out_in.offset_left       = offset[0];
      out_in.offset_middle     = offset[1];
      out_in.offset_right      = offset[2];
   end

   always_ff @(posedge clock) begin
      if (rdy[NS-1]) begin
         out_ff <= out_in;
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = valid_ff[NS-1];
   assign rsp_data  = out_ff;

endmodule

FILE: hw/rtl/tpsc_checker.sv
`include "two_point_sensor_calibration_defines.svh"

module tpsc_checker
   import tpsc_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input tpsc_rsp_type rsp_data
);

   logic slopes_zero;
   logic left_ref;
   logic left_unity;

   assign slopes_zero = (rsp_data.slope_left == '0) && (rsp_data.slope_middle == '0)
                        && (rsp_data.slope_right == '0);
   assign left_ref    = !rsp_data.range_error && (rsp_data.reference_channel == '0);
   assign left_unity  = (rsp_data.slope_left == SLOPE_W'(SLOPE_ONE))
                        && (rsp_data.offset_left == '0);

   `TPSC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `TPSC_ASSERT_IMP(a_ref_range, clock, reset, rsp_valid, rsp_data.reference_channel != 2'd3)
   `TPSC_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_data.range_error, slopes_zero)
   `TPSC_ASSERT_IMP(a_ref_unity, clock, reset, rsp_valid && left_ref, left_unity)
   `TPSC_ASSERT_NXT(a_full_stall, clock, reset, !req_ready, rsp_valid)

endmodule

bind two_point_sensor_calibration tpsc_checker u_tpsc_checker (.*);

FILE: tb/two_point_sensor_calibration_test.sv
module two_point_sensor_calibration_test;
   import tpsc_pkg::*;

   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 2000;
   localparam int DRAIN_CYCLES = 60;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   tpsc_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   tpsc_rsp_type rsp_data;

   two_point_sensor_calibration dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   typedef struct {
      tpsc_req_type samples;
      bit           known;
      tpsc_rsp_type coeffs;
   } stim_row_type;

   tpsc_rsp_type pending_coeffs[$];
   stim_row_type stim_rows[$];
   int           fail_count;
   int           idle_cycles;
   bit           stall_mode;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint round_div(longint num, longint den);
      longint mag;
      longint q;
      begin
         mag = (num < 0) ? -num : num;
         q = (2 * mag + den) / (2 * den);
         return (num < 0) ? -q : q;
      end
   endfunction

   function automatic tpsc_rsp_type calibrate(tpsc_req_type s);
      longint       lt[3];
      longint       dk[3];
      longint       out_rng;
      longint       in_rng;
      longint       slp[3];
      longint       ofs[3];
      int           rc;
      bit           err;
      tpsc_rsp_type r;
      begin
         lt[0] = s.light_left;  lt[1] = s.light_middle; lt[2] = s.light_right;
         dk[0] = s.dark_left;   dk[1] = s.dark_middle;  dk[2] = s.dark_right;
         rc = 0;
         err = 1'b0;
         for (int c = 1; c < 3; c++) if (lt[c] > lt[rc]) rc = c;
         out_rng = lt[rc] - dk[rc];
         for (int c = 0; c < 3; c++) begin
            if (c == rc) begin
               slp[c] = SLOPE_ONE;
               ofs[c] = 0;
            end else begin
               in_rng = lt[c] - dk[c];
               if (in_rng <= 0 || out_rng <= 0) begin
                  err = 1'b1;
                  slp[c] = 0;
                  ofs[c] = 0;
               end else begin
                  slp[c] = round_div(100 * out_rng, in_rng);
                  ofs[c] = round_div(100 * dk[rc] * in_rng - 100 * out_rng * dk[c], in_rng);
               end
            end
         end
         r = '0;
         r.reference_channel = rc[REF_W-1:0];
         r.range_error = err;
         if (!err) begin
            r.slope_left    = slp[0][SLOPE_W-1:0];
            r.slope_middle  = slp[1][SLOPE_W-1:0];
            r.slope_right   = slp[2][SLOPE_W-1:0];
            r.offset_left   = ofs[0][OFFSET_W-1:0];
            r.offset_middle = ofs[1][OFFSET_W-1:0];
            r.offset_right  = ofs[2][OFFSET_W-1:0];
         end
         return r;
      end
   endfunction

   function automatic tpsc_req_type make_set(int ll, int lm, int lr, int dl, int dm, int dr);
      tpsc_req_type s;
      begin
         s.light_left = ll[11:0];  s.light_middle = lm[11:0]; s.light_right = lr[11:0];
         s.dark_left = dl[11:0];   s.dark_middle = dm[11:0];  s.dark_right = dr[11:0];
         return s;
      end
   endfunction

   task automatic add_row(tpsc_req_type s, bit known, tpsc_rsp_type r);
      stim_row_type row;
      begin
         row.samples = s;
         row.known = known;
         row.coeffs = r;
         stim_rows.push_back(row);
      end
   endtask

   function automatic tpsc_rsp_type fixed(int rc, bit err, int sl, int sm, int sr);
      tpsc_rsp_type r;
      begin
         r = '0;
         r.reference_channel = rc[REF_W-1:0];
         r.range_error = err;
         r.slope_left = sl[SLOPE_W-1:0];
         r.slope_middle = sm[SLOPE_W-1:0];
         r.slope_right = sr[SLOPE_W-1:0];
         return r;
      end
   endfunction

   function automatic tpsc_req_type random_set();
      tpsc_req_type s;
      logic [95:0]  raw;
      int           mode;
      begin
         raw = {$urandom, $urandom, $urandom};
         s = raw[$bits(tpsc_req_type)-1:0];
         mode = $urandom_range(0, 9);
         if (mode < 7) begin
            // light drawn above dark on every channel; modes 0 and 1 then overwrite some samples
            s.dark_left = SAMPLE_BITS'($urandom_range(0, 4094));
            s.light_left = SAMPLE_BITS'($urandom_range(s.dark_left + 1, 4095));
            s.dark_middle = SAMPLE_BITS'($urandom_range(0, 4094));
            s.light_middle = SAMPLE_BITS'($urandom_range(s.dark_middle + 1, 4095));
            s.dark_right = SAMPLE_BITS'($urandom_range(0, 4094));
            s.light_right = SAMPLE_BITS'($urandom_range(s.dark_right + 1, 4095));
            if (mode == 0) s.light_middle = s.light_left;
            if (mode == 1) begin
               s.dark_left = SAMPLE_BITS'($urandom_range(0, 3));
               s.dark_middle = SAMPLE_BITS'($urandom_range(0, 3));
               s.dark_right = SAMPLE_BITS'($urandom_range(0, 3));
            end
         end else if (mode == 7) begin
            s.dark_right = s.light_right;
         end
         return s;
      end
   endfunction

   task automatic send(tpsc_req_type s, tpsc_rsp_type e);
      begin
         req_data <= s;
         req_valid <= 1'b1;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         pending_coeffs.push_back(e);
      end
   endtask

   task automatic maybe_gap(ref int burst);
      begin
         if (burst > 0) begin
            burst--;
         end else begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst = $urandom_range(0, 20);
         end
      end
   endtask

   task automatic wait_drained();
      begin
         req_valid <= 1'b0;
         while (pending_coeffs.size() != 0) @(posedge clock);
      end
   endtask

   task automatic compare_field(string name, longint exp_v, longint act_v);
      begin
         if (exp_v != act_v) begin
            $error("%s expected %0d got %0d", name, exp_v, act_v);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_coeffs.size() == 0) begin
            $error("unexpected transfer on rsp");
            fail_count++;
         end else begin
            tpsc_rsp_type e;
            e = pending_coeffs.pop_front();
            compare_field("reference_channel", e.reference_channel, rsp_data.reference_channel);
            compare_field("range_error", e.range_error, rsp_data.range_error);
            compare_field("slope_left", e.slope_left, rsp_data.slope_left);
            compare_field("slope_middle", e.slope_middle, rsp_data.slope_middle);
            compare_field("slope_right", e.slope_right, rsp_data.slope_right);
            compare_field("offset_left", e.offset_left, rsp_data.offset_left);
            compare_field("offset_middle", e.offset_middle, rsp_data.offset_middle);
            compare_field("offset_right", e.offset_right, rsp_data.offset_right);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_mode <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
         rsp_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("two_point_sensor_calibration_test: errors");
            $finish;
         end
      end
   end

   initial begin
      int burst;
      fail_count = 0;
      idle_cycles = 0;
      burst = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      add_row(make_set(4095, 0, 0, 0, 0, 0), 1'b1, fixed(0, 1, 0, 0, 0));
      add_row(make_set(4095, 4095, 4095, 0, 0, 0), 1'b1, fixed(0, 0, 100, 100, 100));
      add_row(make_set(0, 0, 0, 0, 0, 0), 1'b1, fixed(0, 1, 0, 0, 0));
      add_row(make_set(100, 200, 300, 0, 0, 0), 1'b1, fixed(2, 0, 300, 150, 100));
      add_row(make_set(10, 4095, 5, 20, 0, 0), 1'b1, fixed(1, 1, 0, 0, 0));
      add_row(make_set(2, 2, 4095, 0, 0, 4095), 1'b1, fixed(2, 1, 0, 0, 0));
      add_row(make_set(1, 4095, 1, 0, 0, 0), 1'b0, '0);
      add_row(make_set(4095, 1, 4095, 4094, 0, 4094), 1'b0, '0);
      add_row(make_set(4095, 4095, 1, 0, 4094, 0), 1'b0, '0);
      add_row(make_set(4094, 4095, 4095, 4093, 0, 1), 1'b0, '0);
      add_row(make_set(3, 4095, 1000, 0, 0, 999), 1'b0, '0);
      add_row(make_set(3000, 2000, 1000, 2999, 1000, 0), 1'b0, '0);
      add_row(make_set(4095, 4095, 4095, 4095, 4094, 4094), 1'b0, '0);
      add_row(make_set(2048, 2047, 1365, 1024, 682, 341), 1'b0, '0);
      add_row(make_set(7, 3, 9, 2, 1, 4), 1'b0, '0);
      add_row(make_set(4095, 3, 2, 0, 0, 0), 1'b0, '0);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (stim_rows[i]) begin
         send(stim_rows[i].samples,
              stim_rows[i].known ? stim_rows[i].coeffs : calibrate(stim_rows[i].samples));
         maybe_gap(burst);
      end
      wait_drained();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         tpsc_req_type s;
         s = random_set();
         send(s, calibrate(s));
         if (n == RANDOM_ITEMS / 2) wait_drained();
         else maybe_gap(burst);
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_coeffs.size() == 0) begin
         $display("two_point_sensor_calibration_test: clean");
      end else begin
         $display("two_point_sensor_calibration_test: errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/tpsc_pkg.sv
hw/rtl/tpsc_front.sv
hw/rtl/tpsc_div_lane.sv
hw/rtl/two_point_sensor_calibration.sv
hw/rtl/tpsc_checker.sv
tb/two_point_sensor_calibration_test.sv
